FILE: rtl/medpr_pkg.sv
// ----------------------------------------------------------------------------
// medpr_pkg
// Shared constants for the median edge detector pixel reconstruction unit.
// ----------------------------------------------------------------------------
package medpr_pkg;

  // Line buffer depth and derived widths.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Field and register widths.
  localparam int PIX_W     = 8;
  localparam int RES_W     = 9;
  localparam int FWIDTH_W  = 12;
  localparam int FHEIGHT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Reset frame geometry, stored as last column and last row.
  localparam logic [COL_W-1:0]     LAST_COL_RST = COL_W'(639);
  localparam logic [FHEIGHT_W-1:0] LAST_ROW_RST = 16'd479;

  // Median edge detector: a is left, b is above, c is upper-left.
  function automatic logic [PIX_W-1:0] med_predict(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) begin
      return lo;
    end else if (c <= lo) begin
      return hi;
    end
    return PIX_W'(a + b - c);
  endfunction

endpackage

FILE: rtl/med_predictive_pixel_reconstruction_unit.sv
// A request accepted into stage one moves to the output register when that
// register is free. One pixel per cycle unless the output stalls; the line
// buffer read is issued at accept and its data is ready in stage one.
// Reset clears the position counters, the pipeline valids and the neighbor
// pixels and loads a 640 x 480 frame; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// med_predictive_pixel_reconstruction_unit
// Rebuilds an 8-bit plane from per-pixel residuals with MED prediction,
// keeping the previous row in a simple dual-port synchronous line buffer.
// ----------------------------------------------------------------------------
module med_predictive_pixel_reconstruction_unit
  import medpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // Residual input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [RES_W-1:0] residual_i,
  // Pixel output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     pixel_o,
  output logic                 end_of_frame_o
);

  // Frame geometry and position.
  logic [COL_W-1:0]     last_col_q, last_col_d;
  logic [FHEIGHT_W-1:0] last_row_q, last_row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [FHEIGHT_W-1:0] row_q, row_d;

  // Stage one: read issued, waiting for line buffer data.
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_row0_q;
  logic             s1_col0_q;
  logic             s1_last_q;
  logic [PIX_W-1:0] s1_res_q;
  logic             fwd_hit_q;
  logic [PIX_W-1:0] fwd_data_q;

  // Line buffer.
  logic [PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rdata_q;

  // Neighbor pixels and output register.
  logic [PIX_W-1:0] left_q;
  logic [PIX_W-1:0] upleft_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_q;
  logic             eof_q;

  logic             out_free;
  logic             s1_adv;
  logic             accept;
  logic             at_last_col;
  logic             at_last_row;
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] pred;
  logic [PIX_W-1:0] pix;
  logic             fwd_hit_d;
  logic [FWIDTH_W-1:0]  cfg_w;
  logic [FHEIGHT_W-1:0] cfg_h;

  // Handshake: stage one moves on when the output register is free.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign at_last_col = (col_q == last_col_q);
  assign at_last_row = (row_q == last_row_q);

  // Effective geometry for a configuration write.
  assign cfg_w = cfg_data_i[FWIDTH_W-1:0];
  assign cfg_h = cfg_data_i[FHEIGHT_W-1:0];

  // Next geometry and raster position.
  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    col_d      = col_q;
    row_d      = row_q;
    if (cfg_we_i && (cfg_index_i == CFG_FRAME_WIDTH)) begin
      if (cfg_w == '0) begin
        last_col_d = '0;
      end else if (int'(cfg_w) > MAX_WIDTH) begin
        last_col_d = COL_W'(MAX_WIDTH - 1);
      end else begin
        last_col_d = COL_W'(cfg_w - FWIDTH_W'(1));
      end
      col_d = '0;
      row_d = '0;
    end else if (cfg_we_i && (cfg_index_i == CFG_FRAME_HEIGHT)) begin
      last_row_d = (cfg_h == '0) ? '0 : cfg_h - FHEIGHT_W'(1);
      col_d      = '0;
      row_d      = '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_d = '0;
        row_d = at_last_row ? '0 : row_q + FHEIGHT_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // A write by the item leaving stage one to the entry the new item reads.
  assign fwd_hit_d = s1_adv && (s1_col_q == col_q);

  // Prediction and reconstruction for the item in stage one.
  always_comb begin
    if (s1_row0_q) begin
      above = '0;
    end else if (fwd_hit_q) begin
      above = fwd_data_q;
    end else begin
      above = rdata_q;
    end
    if (s1_row0_q) begin
      pred = s1_col0_q ? '0 : left_q;
    end else if (s1_col0_q) begin
      pred = above;
    end else begin
      pred = med_predict(left_q, above, upleft_q);
    end
    pix = s1_res_q + pred;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q  <= LAST_COL_RST;
      last_row_q  <= LAST_ROW_RST;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      upleft_q    <= '0;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      col_q      <= col_d;
      row_q      <= row_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        left_q      <= pix;
        upleft_q    <= above;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage one payload, captured with each accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= col_q;
      s1_row0_q  <= (row_q == '0);
      s1_col0_q  <= (col_q == '0);
      s1_last_q  <= at_last_col && at_last_row;
      s1_res_q   <= residual_i[PIX_W-1:0];
      fwd_hit_q  <= fwd_hit_d;
      fwd_data_q <= pix;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_q <= pix;
      eof_q   <= s1_last_q;
    end
  end

  // Line buffer: read at accept, write back when the pixel is finished.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_col_q] <= pix;
    end
    if (accept) begin
      rdata_q <= row_mem[col_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_o        = pixel_q;
  assign end_of_frame_o = eof_q;

endmodule

FILE: rtl/medpr_checker.sv
// ----------------------------------------------------------------------------
// medpr_checker
// Port-level checks for the pixel reconstruction unit, bound to the top level.
// ----------------------------------------------------------------------------
module medpr_checker
  import medpr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [CFG_DAT_W-1:0] cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [RES_W-1:0]     residual_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [PIX_W-1:0]     pixel_o,
  input logic                 end_of_frame_o
);

  // A stalled result stays and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_o)
      && $stable(end_of_frame_o))
    else $error("stalled result changed");

  // The input only stalls when a result is held back downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // An accepted request reaches the output if the output is not stalled while it is in stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted request did not reach the output");

  // A stalled input request stays and keeps its residual.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(residual_i))
    else $error("stalled request changed");

  // Registers are written only while the block is idle, with known values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_valid_i && !out_valid_o
      && !$isunknown({cfg_index_i, cfg_data_i}))
    else $error("register write while busy");

endmodule

bind med_predictive_pixel_reconstruction_unit medpr_checker u_medpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .cfg_index_i    (cfg_index_i),
  .cfg_data_i     (cfg_data_i),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .residual_i     (residual_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_o        (pixel_o),
  .end_of_frame_o (end_of_frame_o)
);
